### src/cfx_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cfx_pkg
// shared types, codes and defaults of the fixed-point 2-d convolution block
// ----------------------------------------------------------------------------
package cfx_pkg;

  localparam int DEF_MAX_IN_CHANNELS  = 16;
  localparam int DEF_MAX_OUT_CHANNELS = 16;
  localparam int DEF_MAX_KERNEL       = 7;
  localparam int DEF_MAX_HEIGHT       = 64;
  localparam int DEF_MAX_WIDTH        = 64;

  localparam logic [1:0] CMD_WEIGHT  = 2'd0;
  localparam logic [1:0] CMD_BIAS    = 2'd1;
  localparam logic [1:0] CMD_SAMPLE  = 2'd2;
  localparam logic [1:0] CMD_COMPUTE = 2'd3;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_SAT   = 2'd1;
  localparam logic [1:0] STAT_RANGE = 2'd2;

  localparam logic [2:0] REG_IN_USED  = 3'd0;
  localparam logic [2:0] REG_OUT_USED = 3'd1;
  localparam logic [2:0] REG_KSIZE    = 3'd2;
  localparam logic [2:0] REG_STRIDE   = 3'd3;
  localparam logic [2:0] REG_PADDING  = 3'd4;
  localparam logic [2:0] REG_HEIGHT   = 3'd5;
  localparam logic [2:0] REG_WIDTH    = 3'd6;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_DONE
  } back_state_t;

  // register values as the datapath uses them (out_used, padding unclamped)
  typedef struct packed {
    logic [4:0] in_used;
    logic [4:0] out_used;
    logic [2:0] ksize;
    logic [2:0] stride;
    logic [1:0] padding;
    logic [6:0] height;
    logic [6:0] width;
  } cfg_t;

  typedef struct packed {
    logic [1:0]         cmd;
    logic               ok;
    logic [3:0]         out_channel;
    logic [3:0]         in_channel;
    logic [5:0]         row_index;
    logic [5:0]         col_index;
    logic signed [31:0] value;
    logic signed [15:0] sval;
  } entry_t;

endpackage : cfx_pkg
`default_nettype wire

### src/cfx_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cfx_front
// decodes a command beat: store bounds check and 16-bit saturation
// ----------------------------------------------------------------------------
module cfx_front #(
  parameter int MAX_IN_CHANNELS  = cfx_pkg::DEF_MAX_IN_CHANNELS,
  parameter int MAX_OUT_CHANNELS = cfx_pkg::DEF_MAX_OUT_CHANNELS,
  parameter int MAX_KERNEL       = cfx_pkg::DEF_MAX_KERNEL,
  parameter int MAX_HEIGHT       = cfx_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_WIDTH        = cfx_pkg::DEF_MAX_WIDTH
) (
  input  wire logic [1:0]         command,
  input  wire logic [3:0]         out_channel,
  input  wire logic [3:0]         in_channel,
  input  wire logic [5:0]         row_index,
  input  wire logic [5:0]         col_index,
  input  wire logic signed [31:0] value,
  output cfx_pkg::entry_t         entry
);
  import cfx_pkg::*;

  logic oc_in, ic_in;

  always_comb begin
    oc_in = int'(out_channel) < MAX_OUT_CHANNELS;
    ic_in = int'(in_channel) < MAX_IN_CHANNELS;
    entry.cmd         = command;
    entry.out_channel = out_channel;
    entry.in_channel  = in_channel;
    entry.row_index   = row_index;
    entry.col_index   = col_index;
    entry.value       = value;
    if (value > 32'sd32767) begin
      entry.sval = 16'sh7fff;
    end else if (value < -32'sd32768) begin
      entry.sval = -16'sh8000;
    end else begin
      entry.sval = value[15:0];
    end
    case (command)
      CMD_WEIGHT: begin
        entry.ok = oc_in && ic_in && (int'(row_index) < MAX_KERNEL)
                   && (int'(col_index) < MAX_KERNEL);
      end
      CMD_BIAS: begin
        entry.ok = oc_in;
      end
      CMD_SAMPLE: begin
        entry.ok = ic_in && (int'(row_index) < MAX_HEIGHT)
                   && (int'(col_index) < MAX_WIDTH);
      end
      default: begin
        entry.ok = 1'b1;
      end
    endcase
  end

endmodule : cfx_front
`default_nettype wire

### src/cfx_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cfx_queue
// two-entry queue of decoded beats between front and back
// ----------------------------------------------------------------------------
module cfx_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire cfx_pkg::entry_t push_entry,
  input  wire logic            pop,
  output cfx_pkg::entry_t      head,
  output logic                 head_valid,
  output logic                 full
);
  import cfx_pkg::*;

  entry_t     slots [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  assign head       = slots[rd_ptr];
  assign head_valid = count != 2'd0;
  assign full       = count == 2'd2;

endmodule : cfx_queue
`default_nettype wire

### src/cfx_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cfx_back
// stores and the multiply-accumulate sequencer
// ----------------------------------------------------------------------------
module cfx_back #(
  parameter int MAX_IN_CHANNELS  = cfx_pkg::DEF_MAX_IN_CHANNELS,
  parameter int MAX_OUT_CHANNELS = cfx_pkg::DEF_MAX_OUT_CHANNELS,
  parameter int MAX_KERNEL       = cfx_pkg::DEF_MAX_KERNEL,
  parameter int MAX_HEIGHT       = cfx_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_WIDTH        = cfx_pkg::DEF_MAX_WIDTH
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire cfx_pkg::cfg_t   cfg,
  input  wire cfx_pkg::entry_t head,
  input  wire logic            head_valid,
  output logic                 pop,
  output logic                 done,
  output logic signed [31:0]   conv_result,
  output logic [3:0]           result_channel,
  output logic [5:0]           result_row,
  output logic [5:0]           result_col,
  output logic [1:0]           status
);
  import cfx_pkg::*;

  localparam int WDEPTH = MAX_OUT_CHANNELS * MAX_IN_CHANNELS * MAX_KERNEL * MAX_KERNEL;
  localparam int IDEPTH = MAX_IN_CHANNELS * MAX_HEIGHT * MAX_WIDTH;
  localparam int WA_W   = WDEPTH > 1 ? $clog2(WDEPTH) : 1;
  localparam int IA_W   = IDEPTH > 1 ? $clog2(IDEPTH) : 1;
  localparam int OC_W   = MAX_OUT_CHANNELS > 1 ? $clog2(MAX_OUT_CHANNELS) : 1;
  localparam int CH_W   = MAX_IN_CHANNELS > 1 ? $clog2(MAX_IN_CHANNELS) : 1;
  localparam int K_W    = MAX_KERNEL > 1 ? $clog2(MAX_KERNEL) : 1;
  localparam int ACC_W  = 34 + $clog2(MAX_IN_CHANNELS * MAX_KERNEL * MAX_KERNEL);
  localparam int POS_W  = 12;

  logic signed [15:0] weight_mem [WDEPTH];
  logic signed [15:0] image_mem  [IDEPTH];
  logic signed [31:0] bias_mem   [MAX_OUT_CHANNELS];

  back_state_t state, state_next;

  logic [8:0]       rs, cs;
  logic [POS_W-1:0] span_h, span_w;
  logic             in_range, is_compute, start_comp, range_fail, issue, last_tap;
  logic [WA_W-1:0]  ld_waddr;
  logic [IA_W-1:0]  ld_iaddr;

  logic [3:0]              oc;
  logic [5:0]              row, col;
  logic signed [POS_W-1:0] base_r, base_c;
  logic [CH_W-1:0]         ch;
  logic [K_W-1:0]          kh, kw;
  logic [1:0]              drain;

  logic signed [POS_W-1:0] ih, iw;
  logic                    tap_ok;

  logic                    s1_valid, s1_ok, s2_valid, s2_ok, s3_valid;
  logic [WA_W-1:0]         s1_waddr;
  logic [IA_W-1:0]         s1_iaddr;
  logic signed [15:0]      wdat, idat;
  logic signed [31:0]      prod;
  logic signed [ACC_W-1:0] acc;
  logic                    sat_hi, sat_lo;

  // position check, load addresses, tap bounds and saturation flags
  always_comb begin
    rs     = 9'(head.row_index) * 9'(cfg.stride);
    cs     = 9'(head.col_index) * 9'(cfg.stride);
    span_h = POS_W'(cfg.height) + POS_W'({cfg.padding, 1'b0}) - POS_W'(cfg.ksize);
    span_w = POS_W'(cfg.width) + POS_W'({cfg.padding, 1'b0}) - POS_W'(cfg.ksize);
    in_range = (int'(head.out_channel) < MAX_OUT_CHANNELS)
               && (5'(head.out_channel) < cfg.out_used)
               && !span_h[POS_W-1] && (POS_W'(rs) <= span_h)
               && !span_w[POS_W-1] && (POS_W'(cs) <= span_w);
    ld_waddr = WA_W'(((int'(head.out_channel) * MAX_IN_CHANNELS + int'(head.in_channel))
                     * MAX_KERNEL + int'(head.row_index)) * MAX_KERNEL
                     + int'(head.col_index));
    ld_iaddr = IA_W'((int'(head.in_channel) * MAX_HEIGHT + int'(head.row_index))
                     * MAX_WIDTH + int'(head.col_index));
    last_tap = (int'(kw) == int'(cfg.ksize) - 1) && (int'(kh) == int'(cfg.ksize) - 1)
               && (int'(ch) == int'(cfg.in_used) - 1);
    ih     = base_r + POS_W'(kh);
    iw     = base_c + POS_W'(kw);
    tap_ok = !ih[POS_W-1] && (ih < POS_W'(cfg.height))
             && !iw[POS_W-1] && (iw < POS_W'(cfg.width));
    sat_hi = acc > $signed({{(ACC_W-32){1'b0}}, 32'h7fff_ffff});
    sat_lo = acc < $signed({{(ACC_W-32){1'b1}}, 32'h8000_0000});
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (head_valid && head.cmd == CMD_COMPUTE && in_range) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (last_tap) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (drain == 2'd0) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    pop        = 1'b0;
    issue      = 1'b0;
    is_compute = head.cmd == CMD_COMPUTE;
    case (state)
      ST_IDLE: begin
        pop = head_valid;
      end
      ST_RUN: begin
        issue = 1'b1;
      end
      default: begin
        pop = 1'b0;
      end
    endcase
    start_comp = pop && is_compute && in_range;
    range_fail = pop && is_compute && !in_range;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      state    <= state_next;
      s1_valid <= issue;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      done     <= range_fail || state == ST_DONE;
    end
  end

  // stores and operand reads
  always_ff @(posedge clk) begin
    if (pop && head.ok && head.cmd == CMD_WEIGHT) begin
      weight_mem[ld_waddr] <= head.sval;
    end
    if (pop && head.ok && head.cmd == CMD_SAMPLE) begin
      image_mem[ld_iaddr] <= head.sval;
    end
    if (pop && head.ok && head.cmd == CMD_BIAS) begin
      bias_mem[OC_W'(head.out_channel)] <= head.value;
    end
    wdat <= weight_mem[s1_waddr];
    idat <= image_mem[s1_iaddr];
  end

  // tap sequencer and mac pipeline
  always_ff @(posedge clk) begin
    if (start_comp) begin
      oc     <= head.out_channel;
      row    <= head.row_index;
      col    <= head.col_index;
      base_r <= POS_W'(rs) - POS_W'(cfg.padding);
      base_c <= POS_W'(cs) - POS_W'(cfg.padding);
      ch     <= '0;
      kh     <= '0;
      kw     <= '0;
      acc    <= ACC_W'(bias_mem[OC_W'(head.out_channel)]);
    end else begin
      if (issue) begin
        if (int'(kw) == int'(cfg.ksize) - 1) begin
          kw <= '0;
          if (int'(kh) == int'(cfg.ksize) - 1) begin
            kh <= '0;
            ch <= ch + 1'b1;
          end else begin
            kh <= kh + 1'b1;
          end
        end else begin
          kw <= kw + 1'b1;
        end
      end
      if (s3_valid) begin
        acc <= acc + ACC_W'(prod);
      end
    end
    if (state == ST_RUN) begin
      drain <= 2'd2;
    end else if (state == ST_DRAIN) begin
      drain <= drain - 2'd1;
    end
    s1_ok    <= tap_ok;
    s1_waddr <= WA_W'(((int'(oc) * MAX_IN_CHANNELS + int'(ch)) * MAX_KERNEL + int'(kh))
                      * MAX_KERNEL + int'(kw));
    s1_iaddr <= IA_W'((int'(ch) * MAX_HEIGHT + int'(ih)) * MAX_WIDTH + int'(iw));
    s2_ok    <= s1_ok;
    prod     <= s2_ok ? wdat * idat : 32'sd0;
  end

  // result register
  always_ff @(posedge clk) begin
    if (range_fail) begin
      conv_result    <= 32'sd0;
      result_channel <= head.out_channel;
      result_row     <= head.row_index;
      result_col     <= head.col_index;
      status         <= STAT_RANGE;
    end else if (state == ST_DONE) begin
      result_channel <= oc;
      result_row     <= row;
      result_col     <= col;
      if (sat_hi) begin
        conv_result <= 32'sh7fff_ffff;
        status      <= STAT_SAT;
      end else if (sat_lo) begin
        conv_result <= 32'sh8000_0000;
        status      <= STAT_SAT;
      end else begin
        conv_result <= acc[31:0];
        status      <= STAT_OK;
      end
    end
  end

  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    state == ST_DONE |=> done)
    else $error("finished compute gave no result beat");

  a_range_zero: assert property (@(posedge clk) disable iff (rst)
    done && status == STAT_RANGE |-> conv_result == 32'sd0)
    else $error("out-of-range result not zero");

  a_drain_end: assert property (@(posedge clk) disable iff (rst)
    state == ST_DRAIN && drain == 2'd0 |=> state == ST_DONE && !s3_valid)
    else $error("mac pipeline not empty at finish");

  a_no_pop_busy: assert property (@(posedge clk) disable iff (rst)
    state != ST_IDLE |-> !pop)
    else $error("queue popped while computing");

endmodule : cfx_back
`default_nettype wire

### src/conv2d_forward_fixed.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// conv2d_forward_fixed
// strided zero-padded 2-d convolution, q8.8 operands, q16.16 saturated result
//
//   channel  signals                                     flow
//   command  start/busy, command..value                  in, beat on start & !busy
//   result   done, conv_result..status                   out, one cycle per beat
//   config   cfg_wen, cfg_index, cfg_data                in, write every cycle
//
// loads are stored as the idle back end pops them; a compute beat steps
// through in_used * ksize^2 taps of the single mac loop, then drains its pipeline
// out-of-range computes give zero and range status; no store is cleared at reset
// busy is high only while the two-entry command queue is full
// ----------------------------------------------------------------------------
module conv2d_forward_fixed #(
  parameter int MAX_IN_CHANNELS  = cfx_pkg::DEF_MAX_IN_CHANNELS,
  parameter int MAX_OUT_CHANNELS = cfx_pkg::DEF_MAX_OUT_CHANNELS,
  parameter int MAX_KERNEL       = cfx_pkg::DEF_MAX_KERNEL,
  parameter int MAX_HEIGHT       = cfx_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_WIDTH        = cfx_pkg::DEF_MAX_WIDTH
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [1:0]         command,
  input  wire logic [3:0]         out_channel,
  input  wire logic [3:0]         in_channel,
  input  wire logic [5:0]         row_index,
  input  wire logic [5:0]         col_index,
  input  wire logic signed [31:0] value,
  input  wire logic               cfg_wen,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [6:0]         cfg_data,
  output logic                    done,
  output logic signed [31:0]      conv_result,
  output logic [3:0]              result_channel,
  output logic [5:0]              result_row,
  output logic [5:0]              result_col,
  output logic [1:0]              status
);
  import cfx_pkg::*;

  logic [4:0] in_used, out_used;
  logic [2:0] ksize, stride;
  logic [1:0] padding;
  logic [6:0] height, width;
  cfg_t       cfg;
  entry_t     entry, head;
  logic       head_valid, pop, full;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_used  <= 5'd1;
      out_used <= 5'd1;
      ksize    <= 3'd3;
      stride   <= 3'd1;
      padding  <= 2'd0;
      height   <= 7'd64;
      width    <= 7'd64;
    end else if (cfg_wen) begin
      case (cfg_index)
        REG_IN_USED:  in_used  <= cfg_data[4:0];
        REG_OUT_USED: out_used <= cfg_data[4:0];
        REG_KSIZE:    ksize    <= cfg_data[2:0];
        REG_STRIDE:   stride   <= cfg_data[2:0];
        REG_PADDING:  padding  <= cfg_data[1:0];
        REG_HEIGHT:   height   <= cfg_data;
        REG_WIDTH:    width    <= cfg_data;
        default:      ;
      endcase
    end
  end

  // clamp all but out_used and padding into working ranges
  always_comb begin
    cfg.out_used = out_used;
    cfg.padding  = padding;
    cfg.stride   = (stride == 3'd0) ? 3'd1 : stride;
    cfg.in_used  = (in_used == 5'd0) ? 5'd1 :
                   (int'(in_used) > MAX_IN_CHANNELS) ? 5'(MAX_IN_CHANNELS) : in_used;
    cfg.ksize    = (ksize == 3'd0) ? 3'd1 :
                   (int'(ksize) > MAX_KERNEL) ? 3'(MAX_KERNEL) : ksize;
    cfg.height   = (height == 7'd0) ? 7'd1 :
                   (int'(height) > MAX_HEIGHT) ? 7'(MAX_HEIGHT) : height;
    cfg.width    = (width == 7'd0) ? 7'd1 :
                   (int'(width) > MAX_WIDTH) ? 7'(MAX_WIDTH) : width;
  end

  assign busy = full;

  cfx_front #(
    .MAX_IN_CHANNELS  (MAX_IN_CHANNELS),
    .MAX_OUT_CHANNELS (MAX_OUT_CHANNELS),
    .MAX_KERNEL       (MAX_KERNEL),
    .MAX_HEIGHT       (MAX_HEIGHT),
    .MAX_WIDTH        (MAX_WIDTH)
  ) u_front (
    .command     (command),
    .out_channel (out_channel),
    .in_channel  (in_channel),
    .row_index   (row_index),
    .col_index   (col_index),
    .value       (value),
    .entry       (entry)
  );

  cfx_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (start && !busy),
    .push_entry (entry),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid),
    .full       (full)
  );

  cfx_back #(
    .MAX_IN_CHANNELS  (MAX_IN_CHANNELS),
    .MAX_OUT_CHANNELS (MAX_OUT_CHANNELS),
    .MAX_KERNEL       (MAX_KERNEL),
    .MAX_HEIGHT       (MAX_HEIGHT),
    .MAX_WIDTH        (MAX_WIDTH)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .head           (head),
    .head_valid     (head_valid),
    .pop            (pop),
    .done           (done),
    .conv_result    (conv_result),
    .result_channel (result_channel),
    .result_row     (result_row),
    .result_col     (result_col),
    .status         (status)
  );

endmodule : conv2d_forward_fixed
`default_nettype wire

### test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// conv2d_forward_fixed testbench
// loads weights, biases and samples, then issues compute beats over several
// register settings; every result is checked against the value given with
// a typed directed beat, or else against a built-in convolution predictor
// that tracks the stores and only reads entries already written
module testbench;
  import cfx_pkg::*;

  localparam int NIC = 16;
  localparam int NOC = 16;
  localparam int NK = 7;
  localparam int NH = 64;
  localparam int NW = 64;
  localparam int STALL_LIMIT = 8000;
  localparam int SETTLE = 20;
  localparam int RAND_PER_PHASE = 18;

  typedef struct {
    logic [1:0]         cmd;
    logic [3:0]         oc;
    logic [3:0]         ic;
    logic [5:0]         r;
    logic [5:0]         c;
    logic signed [31:0] val;
    bit                 typed;
    logic signed [31:0] t_res;
    logic [1:0]         t_stat;
  } beat_t;

  typedef struct packed {
    logic signed [31:0] res;
    logic [3:0]         ch;
    logic [5:0]         row;
    logic [5:0]         col;
    logic [1:0]         stat;
  } conv_out_t;

  typedef struct {
    int in_u, out_u, k, s, p, h, w;
    int oc_load, rows_load, cols_load;
  } phase_t;

  logic               clk = 0;
  logic               rst = 1;
  logic               start = 0;
  logic               busy;
  logic [1:0]         command = '0;
  logic [3:0]         out_channel = '0;
  logic [3:0]         in_channel = '0;
  logic [5:0]         row_index = '0;
  logic [5:0]         col_index = '0;
  logic signed [31:0] value = '0;
  logic               cfg_wen = 0;
  logic [2:0]         cfg_index = '0;
  logic [6:0]         cfg_data = '0;
  logic               done;
  logic signed [31:0] conv_result;
  logic [3:0]         result_channel;
  logic [5:0]         result_row;
  logic [5:0]         result_col;
  logic [1:0]         status;

  conv2d_forward_fixed dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .command(command), .out_channel(out_channel), .in_channel(in_channel),
    .row_index(row_index), .col_index(col_index), .value(value),
    .cfg_wen(cfg_wen), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .done(done), .conv_result(conv_result), .result_channel(result_channel),
    .result_row(result_row), .result_col(result_col), .status(status)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // mirrored stores and registers
  logic signed [15:0] weight_mem [NOC][NIC][NK][NK];
  bit                 weight_seen [NOC][NIC][NK][NK];
  logic signed [31:0] bias_mem [NOC];
  bit                 bias_seen [NOC];
  logic signed [15:0] sample_mem [NIC][NH][NW];
  bit                 sample_seen [NIC][NH][NW];
  logic [4:0] in_used_q = 1;
  logic [4:0] out_used_q = 1;
  logic [2:0] ksize_q = 3;
  logic [2:0] stride_q = 1;
  logic [1:0] pad_q = 0;
  logic [6:0] height_q = 64;
  logic [6:0] width_q = 64;

  conv_out_t conv_pending_q[$];
  int errors = 0;
  int quiet_cycles = 0;
  int burst_left = 0;

  function automatic int clamp_reg(int v, int hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int out_len(int n, int p, int k, int s);
    int span;
    span = n + 2 * p - k;
    if (span < 0) return 0;
    return span / s + 1;
  endfunction

  function automatic logic signed [15:0] sat16(longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  function automatic void geometry(output int nin, output int k, output int s,
                                   output int p, output int h, output int w);
    nin = clamp_reg(in_used_q, NIC);
    k = clamp_reg(ksize_q, NK);
    s = (stride_q == 0) ? 1 : stride_q;
    p = pad_q;
    h = clamp_reg(height_q, NH);
    w = clamp_reg(width_q, NW);
  endfunction

  function automatic bit position_valid(int oc, int r, int c);
    int nin, k, s, p, h, w;
    geometry(nin, k, s, p, h, w);
    return oc < NOC && oc < out_used_q && r < out_len(h, p, k, s) &&
           c < out_len(w, p, k, s);
  endfunction

  // true when a compute here is out of range or touches only written entries
  function automatic bit window_written(int oc, int r, int c);
    int nin, k, s, p, h, w, ih, iw;
    if (!position_valid(oc, r, c)) return 1;
    if (!bias_seen[oc]) return 0;
    geometry(nin, k, s, p, h, w);
    for (int ch = 0; ch < nin; ch++)
      for (int kh = 0; kh < k; kh++) begin
        ih = r * s - p + kh;
        if (ih < 0 || ih >= h) continue;
        for (int kw = 0; kw < k; kw++) begin
          iw = c * s - p + kw;
          if (iw < 0 || iw >= w) continue;
          if (!weight_seen[oc][ch][kh][kw] || !sample_seen[ch][ih][iw]) return 0;
        end
      end
    return 1;
  endfunction

  function automatic conv_out_t conv_predict(int oc, int r, int c);
    conv_out_t e;
    int nin, k, s, p, h, w, ih, iw;
    longint acc;
    geometry(nin, k, s, p, h, w);
    e.ch = 4'(oc);
    e.row = 6'(r);
    e.col = 6'(c);
    e.stat = STAT_OK;
    e.res = 0;
    if (!position_valid(oc, r, c)) begin
      e.stat = STAT_RANGE;
      return e;
    end
    acc = bias_mem[oc];
    for (int ch = 0; ch < nin; ch++)
      for (int kh = 0; kh < k; kh++) begin
        ih = r * s - p + kh;
        if (ih < 0 || ih >= h) continue;
        for (int kw = 0; kw < k; kw++) begin
          iw = c * s - p + kw;
          if (iw < 0 || iw >= w) continue;
          acc += longint'(weight_mem[oc][ch][kh][kw]) * longint'(sample_mem[ch][ih][iw]);
        end
      end
    if (acc > 64'sd2147483647) begin
      acc = 64'sd2147483647;
      e.stat = STAT_SAT;
    end else if (acc < -64'sd2147483648) begin
      acc = -64'sd2147483648;
      e.stat = STAT_SAT;
    end
    e.res = acc[31:0];
    return e;
  endfunction

  function automatic void store_load(beat_t b);
    case (b.cmd)
      CMD_WEIGHT: begin
        if (b.r < NK && b.c < NK) begin
          weight_mem[b.oc][b.ic][b.r][b.c] = sat16(b.val);
          weight_seen[b.oc][b.ic][b.r][b.c] = 1;
        end
      end
      CMD_BIAS: begin
        bias_mem[b.oc] = b.val;
        bias_seen[b.oc] = 1;
      end
      CMD_SAMPLE: begin
        sample_mem[b.ic][b.r][b.c] = sat16(b.val);
        sample_seen[b.ic][b.r][b.c] = 1;
      end
      default: ;
    endcase
  endfunction

  function automatic beat_t mk(logic [1:0] cmd, int oc, int ic, int r, int c,
                               logic signed [31:0] val);
    beat_t b;
    b.cmd = cmd;
    b.oc = 4'(oc);
    b.ic = 4'(ic);
    b.r = 6'(r);
    b.c = 6'(c);
    b.val = val;
    b.typed = 0;
    b.t_res = 0;
    b.t_stat = STAT_OK;
    return b;
  endfunction

  function automatic beat_t mk_typed(int oc, int r, int c, logic signed [31:0] res,
                                     logic [1:0] st);
    beat_t b;
    b = mk(CMD_COMPUTE, oc, 0, r, c, 0);
    b.typed = 1;
    b.t_res = res;
    b.t_stat = st;
    return b;
  endfunction

  function automatic logic signed [31:0] rand_value();
    logic signed [15:0] h16;
    h16 = 16'($urandom);
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return h16;
      2: return $signed($urandom_range(0, 1200)) - 600;
      default: return {{8{h16[15]}}, h16, 8'h00};
    endcase
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    errors++;
  endtask

  task automatic idle(input int n);
    repeat (n) @(negedge clk) start = 0;
  endtask

  task automatic send(input beat_t b);
    conv_out_t e;
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) idle($urandom_range(1, 12));
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    @(negedge clk);
    start = 1;
    command = b.cmd;
    out_channel = b.oc;
    in_channel = b.ic;
    row_index = b.r;
    col_index = b.c;
    value = b.val;
    do @(posedge clk); while (busy);
    if (b.cmd == CMD_COMPUTE) begin
      e = conv_predict(b.oc, b.r, b.c);
      if (b.typed) begin
        e.res = b.t_res;
        e.stat = b.t_stat;
      end
      conv_pending_q.push_back(e);
    end else begin
      store_load(b);
    end
  endtask

  task automatic drain();
    @(negedge clk) start = 0;
    while (conv_pending_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input int data);
    @(negedge clk);
    cfg_wen = 1;
    cfg_index = idx;
    cfg_data = 7'(data);
    @(negedge clk) cfg_wen = 0;
    case (idx)
      REG_IN_USED:  in_used_q = 5'(data);
      REG_OUT_USED: out_used_q = 5'(data);
      REG_KSIZE:    ksize_q = 3'(data);
      REG_STRIDE:   stride_q = 3'(data);
      REG_PADDING:  pad_q = 2'(data);
      REG_HEIGHT:   height_q = 7'(data);
      default:      width_q = 7'(data);
    endcase
  endtask

  task automatic run_phase(input phase_t ph);
    int nin, k, s, p, h, w, rows, cols, hout, wout, r_hi, c_hi, oc, r, c, tries;
    beat_t b;
    write_reg(REG_IN_USED, ph.in_u);
    write_reg(REG_OUT_USED, ph.out_u);
    write_reg(REG_KSIZE, ph.k);
    write_reg(REG_STRIDE, ph.s);
    write_reg(REG_PADDING, ph.p);
    write_reg(REG_HEIGHT, ph.h);
    write_reg(REG_WIDTH, ph.w);
    geometry(nin, k, s, p, h, w);
    rows = (ph.rows_load < h) ? ph.rows_load : h;
    cols = (ph.cols_load < w) ? ph.cols_load : w;
    hout = out_len(h, p, k, s);
    wout = out_len(w, p, k, s);
    r_hi = (rows + p) / s;
    c_hi = (cols + p) / s;
    if (r_hi > hout - 1) r_hi = hout - 1;
    if (c_hi > wout - 1) c_hi = wout - 1;
    if (r_hi < 0) r_hi = 0;
    if (c_hi < 0) c_hi = 0;
    // well-formed preload of the region that targeted computes read
    for (int o = 0; o < ph.oc_load; o++) begin
      send(mk(CMD_BIAS, o, $urandom_range(0, 15), 0, 0, rand_value()));
      for (int ch = 0; ch < nin; ch++)
        for (int kh = 0; kh < k; kh++)
          for (int kw = 0; kw < k; kw++)
            send(mk(CMD_WEIGHT, o, ch, kh, kw, rand_value()));
    end
    for (int ch = 0; ch < nin; ch++)
      for (int y = 0; y < rows; y++)
        for (int x = 0; x < cols; x++)
          send(mk(CMD_SAMPLE, $urandom_range(0, 15), ch, y, x, rand_value()));
    for (int n = 0; n < RAND_PER_PHASE; n++) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6, 7, 8: begin
          tries = 0;
          do begin
            oc = $urandom_range(0, ph.oc_load - 1);
            r = $urandom_range(0, r_hi);
            c = $urandom_range(0, c_hi);
            tries++;
          end while (!window_written(oc, r, c) && tries < 8);
          if (window_written(oc, r, c)) b = mk(CMD_COMPUTE, oc, $urandom_range(0, 15), r, c,
                                                 $urandom);
          else b = mk(CMD_BIAS, oc, 0, 0, 0, rand_value());
        end
        9, 10: begin
          b = mk(CMD_COMPUTE, $urandom_range(0, 15), $urandom_range(0, 15),
                 $urandom_range(0, 63), $urandom_range(0, 63), $urandom);
          if (!window_written(b.oc, b.r, b.c)) b.cmd = CMD_BIAS;
        end
        11, 12, 13: b = mk(CMD_WEIGHT, $urandom_range(0, ph.oc_load - 1),
                           $urandom_range(0, nin - 1), $urandom_range(0, k - 1),
                           $urandom_range(0, k - 1), rand_value());
        14, 15, 16: b = mk(CMD_SAMPLE, $urandom_range(0, 15), $urandom_range(0, nin - 1),
                           $urandom_range(0, rows - 1), $urandom_range(0, cols - 1),
                           rand_value());
        17: b = mk(CMD_BIAS, $urandom_range(0, ph.oc_load - 1), $urandom_range(0, 15),
                   $urandom_range(0, 63), $urandom_range(0, 63), rand_value());
        default: b = mk(2'($urandom_range(0, 2)), $urandom_range(0, 15),
                        $urandom_range(0, 15), $urandom_range(0, 63),
                        $urandom_range(0, 63), $urandom);
      endcase
      send(b);
    end
    drain();
  endtask

  // result checker and watchdog
  always @(posedge clk) begin
    conv_out_t e;
    if (!rst) begin
      if (done) begin
        if (conv_pending_q.size() == 0) begin
          report_mismatch("result with nothing expected");
        end else begin
          e = conv_pending_q.pop_front();
          if (conv_result !== e.res)
            report_mismatch($sformatf("conv_result %h exp %h", conv_result, e.res));
          if (result_channel !== e.ch)
            report_mismatch($sformatf("result_channel %0d exp %0d", result_channel, e.ch));
          if (result_row !== e.row)
            report_mismatch($sformatf("result_row %0d exp %0d", result_row, e.row));
          if (result_col !== e.col)
            report_mismatch($sformatf("result_col %0d exp %0d", result_col, e.col));
          if (status !== e.stat)
            report_mismatch($sformatf("status %0d exp %0d", status, e.stat));
        end
      end
      if ((start && !busy) || done) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("conv2d_forward_fixed regression: fail");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    beat_t directed_q[$];
    phase_t phases[$];
    repeat (11) @(posedge clk);
    @(negedge clk) rst = 0;

    // reset settings: 3x3 kernel, one channel, 64x64 image, 62x62 output
    directed_q.push_back(mk_typed(1, 0, 0, 0, STAT_RANGE));
    directed_q.push_back(mk_typed(0, 62, 0, 0, STAT_RANGE));
    directed_q.push_back(mk_typed(0, 0, 62, 0, STAT_RANGE));
    for (int i = 0; i < 9; i++)
      directed_q.push_back(mk(CMD_WEIGHT, 0, 0, i / 3, i % 3, 32'sh7fffffff));
    directed_q.push_back(mk(CMD_WEIGHT, 0, 0, 7, 63, 32'sh00001234));
    directed_q.push_back(mk(CMD_BIAS, 0, 15, 63, 63, 32'sh7fffffff));
    for (int i = 0; i < 9; i++)
      directed_q.push_back(mk(CMD_SAMPLE, 15, 0, i / 3, i % 3, 32'sh0000ffff));
    directed_q.push_back(mk(CMD_SAMPLE, 0, 15, 63, 63, 32'sh80000000));
    directed_q.push_back(mk_typed(0, 0, 0, 32'sh7fffffff, STAT_SAT));
    directed_q.push_back(mk(CMD_BIAS, 0, 0, 0, 0, 32'sh80000000));
    directed_q.push_back(mk(CMD_SAMPLE, 0, 0, 1, 1, 32'shfffffed4));
    directed_q.push_back(mk(CMD_COMPUTE, 15, 15, 0, 0, 32'shffffffff));
    foreach (directed_q[i]) send(directed_q[i]);
    drain();

    // in, out, k, stride, pad, h, w, oc loaded, rows loaded, cols loaded
    phases.push_back('{2, 3, 3, 1, 1, 6, 6, 3, 6, 6});
    phases.push_back('{16, 16, 1, 1, 0, 2, 2, 2, 2, 2});
    phases.push_back('{1, 1, 7, 2, 3, 9, 9, 1, 5, 5});
    phases.push_back('{1, 2, 3, 4, 2, 64, 64, 2, 8, 8});
    phases.push_back('{0, 2, 0, 0, 0, 0, 1, 2, 1, 1});
    phases.push_back('{31, 1, 1, 6, 1, 100, 3, 1, 2, 3});
    phases.push_back('{1, 1, 5, 7, 0, 3, 3, 1, 3, 3});
    phases.push_back('{1, 17, 7, 1, 3, 127, 2, 1, 3, 2});
    foreach (phases[i]) run_phase(phases[i]);

    if (errors == 0) begin
      $display("conv2d_forward_fixed regression: pass");
    end else begin
      $display("conv2d_forward_fixed regression: fail");
    end
    $finish;
  end

endmodule
